/* design/axis_gizmo_ray_pick_assert.svh */
// Assertion macros for the axis gizmo ray pick block
`ifndef AXIS_GIZMO_RAY_PICK_ASSERT_SVH
`define AXIS_GIZMO_RAY_PICK_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset
`define AGRP_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("axis_gizmo_ray_pick: assertion failed");

// Next-cycle implication
`define AGRP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("axis_gizmo_ray_pick: assertion failed");

`endif

/* design/agrp_pkg.sv */
// Shared widths, codes and pipeline payload types for the axis gizmo ray pick
package agrp_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int NAX        = 3;
    localparam int POS_W      = 32;
    localparam int DIR_W      = 18;
    localparam int W_W        = 33;
    localparam int SCALE_W    = 31;
    localparam int THF_W      = 16;
    localparam int LNF_W      = 19;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 19;
    localparam int PROD_W     = 51;
    localparam int P_W        = 53;
    localparam int NUM_W      = 54;
    localparam int AN_W       = 54;
    localparam int UU_W       = 36;
    localparam int DEN_W      = 37;
    localparam int AD_W       = 34;
    localparam int LEN_W      = 34;
    localparam int LP_W       = SCALE_W + LNF_W;
    localparam int TP_W       = SCALE_W + THF_W;
    localparam int THR_W      = 31;
    localparam int THR2_W     = 62;
    localparam int SQ_BITS    = 40;
    localparam int S_W        = SQ_BITS + 1;
    localparam int SAT_SHIFT  = SQ_BITS - FRAC_BITS;
    localparam int CMP_W      = AD_W + SAT_SHIFT;
    localparam int TN_W       = 59;
    localparam int T_BITS     = FRAC_BITS;
    localparam int T_W        = T_BITS + 1;
    localparam int MRD_W      = 58;
    localparam int ML_W       = LEN_W + T_W;
    localparam int DF_W       = 44;
    localparam int CAP_W      = 32;
    localparam int SQR_W      = 64;

    localparam logic [UU_W-1:0]  ONE_SQ   = UU_W'(1) << (2 * FRAC_BITS);
    localparam logic [T_W-1:0]   ONE_T    = T_W'(1) << FRAC_BITS;
    localparam logic [CAP_W-1:0] DIFF_CAP = CAP_W'(1) << (CAP_W - 1);

    localparam logic [THF_W-1:0] THF_RESET = 16'd4588;
    localparam logic [LNF_W-1:0] LNF_RESET = 19'd65536;

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH    = 2'd1;

    typedef enum logic [1:0] {
        AXIS_NONE = 2'd0,
        AXIS_X    = 2'd1,
        AXIS_Y    = 2'd2,
        AXIS_Z    = 2'd3
    } axis_t;

    localparam axis_t AXIS_OF [NAX] = '{AXIS_X, AXIS_Y, AXIS_Z};

    // How the segment parameter is formed once the ray parameter is known
    typedef enum logic [1:0] {
        TS_ZERO = 2'b00,
        TS_ONE  = 2'b01,
        TS_DIV  = 2'b10
    } tsel_t;

    typedef struct packed {
        logic [NAX-1:0][W_W-1:0]   w;
        logic [NAX-1:0][DIR_W-1:0] rd;
        logic [LEN_W-1:0]          len;
        logic [THR2_W-1:0]         thr2;
    } common_t;

    typedef struct packed {
        common_t        c;
        logic [NAX-1:0] neg;
        logic [NAX-1:0] sat;
        logic [NAX-1:0] deg;
    } sdiv_side_t;

    typedef struct packed {
        common_t                 c;
        logic [NAX-1:0][S_W-1:0] s;
        tsel_t [NAX-1:0]         tsel;
    } tdiv_side_t;

endpackage

/* design/agrp_div.sv */
// Pipelined restoring divider, one quotient bit per stage, three lanes
module agrp_div
    import agrp_pkg::*;
#(
    parameter int QW = 40,
    parameter int DW = 34,
    parameter int SW = 8
)(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  logic [NAX-1:0][DW-1:0]  in_div,
    input  logic [NAX-1:0][DW-1:0]  in_rem,
    input  logic [NAX-1:0][QW-1:0]  in_low,
    input  logic [SW-1:0]           in_side,
    output logic                    out_valid,
    output logic [NAX-1:0][QW-1:0]  out_quo,
    output logic [SW-1:0]           out_side
);

    logic                   vld_reg  [QW];
    logic [NAX-1:0][DW-1:0] div_reg  [QW];
    logic [NAX-1:0][DW-1:0] rem_reg  [QW];
    logic [NAX-1:0][QW-1:0] low_reg  [QW];
    logic [SW-1:0]          side_reg [QW];

    for (genvar j = 0; j < QW; j++) begin : g_stage
        logic                   cur_vld;
        logic [NAX-1:0][DW-1:0] cur_div;
        logic [NAX-1:0][DW-1:0] cur_rem;
        logic [NAX-1:0][QW-1:0] cur_low;
        logic [SW-1:0]          cur_side;
        logic [NAX-1:0][DW-1:0] rem_next;
        logic [NAX-1:0][QW-1:0] low_next;

        if (j == 0) begin : g_first
            assign cur_vld  = in_valid;
            assign cur_div  = in_div;
            assign cur_rem  = in_rem;
            assign cur_low  = in_low;
            assign cur_side = in_side;
        end else begin : g_next
            assign cur_vld  = vld_reg[j-1];
            assign cur_div  = div_reg[j-1];
            assign cur_rem  = rem_reg[j-1];
            assign cur_low  = low_reg[j-1];
            assign cur_side = side_reg[j-1];
        end

        // bring down the next dividend bit, subtract where it fits
        always_comb begin
            logic [DW:0] trial;
            trial = '0;
            for (int a = 0; a < NAX; a++) begin
                trial = {cur_rem[a], cur_low[a][QW-1]};
                if (trial >= {1'b0, cur_div[a]}) begin
                    rem_next[a] = DW'(trial - {1'b0, cur_div[a]});
                    low_next[a] = {cur_low[a][QW-2:0], 1'b1};
                end else begin
                    rem_next[a] = trial[DW-1:0];
                    low_next[a] = {cur_low[a][QW-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n) begin
            if (!rst_n) begin
                vld_reg[j] <= 1'b0;
            end else begin
                vld_reg[j] <= cur_vld;
            end
        end

        always_ff @(posedge clk) begin
            div_reg[j]  <= cur_div;
            rem_reg[j]  <= rem_next;
            low_reg[j]  <= low_next;
            side_reg[j] <= cur_side;
        end
    end

    assign out_valid = vld_reg[QW-1];
    assign out_quo   = low_reg[QW-1];
    assign out_side  = side_reg[QW-1];

endmodule

/* design/axis_gizmo_ray_pick.sv */
// Top level of the axis gizmo ray pick pipeline
//
// Tests one ray per clock against the three gizmo axis segments and returns the
// nearest axis within tolerance. A query is taken at every edge where start is
// high (busy stays low), and its picked_axis appears with done once the query has
// passed the ray-parameter divider (40 stages, one quotient bit each), the
// segment-parameter divider (16 stages) and 13 stages of multiply, add and compare;
// results leave in query order and cannot be held off. Configuration writes are
// taken in any cycle (cfg_ready is always high).
`include "axis_gizmo_ray_pick_assert.svh"

module axis_gizmo_ray_pick
    import agrp_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [POS_W-1:0]      ray_origin_x,
    input  logic signed [POS_W-1:0]      ray_origin_y,
    input  logic signed [POS_W-1:0]      ray_origin_z,
    input  logic signed [DIR_W-1:0]      ray_dir_x,
    input  logic signed [DIR_W-1:0]      ray_dir_y,
    input  logic signed [DIR_W-1:0]      ray_dir_z,
    input  logic signed [POS_W-1:0]      center_x,
    input  logic signed [POS_W-1:0]      center_y,
    input  logic signed [POS_W-1:0]      center_z,
    input  logic        [SCALE_W-1:0]    gizmo_scale,
    output logic                         done,
    output logic        [1:0]            picked_axis,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic        [CFG_IDX_W-1:0]  cfg_index,
    input  logic        [CFG_DATA_W-1:0] cfg_data
);

    localparam int LATENCY = 13 + SQ_BITS + T_BITS;

    logic [THF_W-1:0] thf_reg;
    logic [LNF_W-1:0] lnf_reg;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            thf_reg <= THF_RESET;
            lnf_reg <= LNF_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_THRESHOLD: thf_reg <= cfg_data[THF_W-1:0];
                CFG_LENGTH:    lnf_reg <= cfg_data;
                default:       ;
            endcase
        end
    end

    // ---------------- stage A: offsets from the gizmo centre
    logic [NAX-1:0][POS_W-1:0] org, ctr;
    logic [NAX-1:0][DIR_W-1:0] dir;
    assign org = {ray_origin_z, ray_origin_y, ray_origin_x};
    assign ctr = {center_z, center_y, center_x};
    assign dir = {ray_dir_z, ray_dir_y, ray_dir_x};

    logic                      a_vld_reg;
    logic [NAX-1:0][W_W-1:0]   a_w_reg;
    logic [NAX-1:0][DIR_W-1:0] a_rd_reg;
    logic [SCALE_W-1:0]        a_scale_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            a_vld_reg <= 1'b0;
        end else begin
            a_vld_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk) begin
        for (int i = 0; i < NAX; i++) begin
            a_w_reg[i] <= W_W'($signed(org[i])) - W_W'($signed(ctr[i]));
        end
        a_rd_reg    <= dir;
        a_scale_reg <= gizmo_scale;
    end

    // ---------------- stage B: products
    logic                       b_vld_reg;
    logic [NAX-1:0][PROD_W-1:0] b_prod_reg;
    logic [NAX-1:0][UU_W-1:0]   b_uu_reg;
    logic [NAX-1:0][W_W-1:0]    b_w_reg;
    logic [NAX-1:0][DIR_W-1:0]  b_rd_reg;
    logic [LEN_W-1:0]           b_len_reg;
    logic [THR_W-1:0]           b_thr_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            b_vld_reg <= 1'b0;
        end else begin
            b_vld_reg <= a_vld_reg;
        end
    end

    always_ff @(posedge clk) begin
        for (int i = 0; i < NAX; i++) begin
            b_prod_reg[i] <= PROD_W'($signed(a_rd_reg[i])) * PROD_W'($signed(a_w_reg[i]));
            b_uu_reg[i]   <= UU_W'($signed(a_rd_reg[i])) * UU_W'($signed(a_rd_reg[i]));
        end
        b_w_reg   <= a_w_reg;
        b_rd_reg  <= a_rd_reg;
        b_len_reg <= LEN_W'((LP_W'(a_scale_reg) * LP_W'(lnf_reg)) >> FRAC_BITS);
        b_thr_reg <= THR_W'((TP_W'(a_scale_reg) * TP_W'(thf_reg)) >> THF_W);
    end

    // ---------------- stage C: numerator, denominator, magnitudes
    logic                     c_vld_reg;
    logic [NAX-1:0][AN_W-1:0] c_an_reg, c_an_next;
    logic [NAX-1:0][AD_W-1:0] c_ad_reg, c_ad_next;
    logic [NAX-1:0]           c_neg_reg, c_neg_next;
    logic [NAX-1:0]           c_deg_reg, c_deg_next;
    common_t                  c_com_reg;

    always_comb begin
        logic signed [P_W-1:0]   p_sum;
        logic signed [NUM_W-1:0] num;
        logic signed [DEN_W-1:0] den;
        p_sum = '0;
        num   = '0;
        den   = '0;
        for (int i = 0; i < NAX; i++) begin
            p_sum = p_sum + P_W'($signed(b_prod_reg[i]));
        end
        for (int k = 0; k < NAX; k++) begin
            num = NUM_W'($signed(b_prod_reg[k])) - NUM_W'(p_sum);
            den = $signed(DEN_W'(ONE_SQ)) - $signed(DEN_W'(b_uu_reg[k]));
            c_an_next[k]  = AN_W'(num[NUM_W-1] ? -num : num);
            c_ad_next[k]  = AD_W'(den[DEN_W-1] ? -den : den);
            c_neg_next[k] = num[NUM_W-1] ^ den[DEN_W-1];
            c_deg_next[k] = (b_len_reg == '0) || (b_uu_reg[k] == ONE_SQ);
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            c_vld_reg <= 1'b0;
        end else begin
            c_vld_reg <= b_vld_reg;
        end
    end

    always_ff @(posedge clk) begin
        c_an_reg       <= c_an_next;
        c_ad_reg       <= c_ad_next;
        c_neg_reg      <= c_neg_next;
        c_deg_reg      <= c_deg_next;
        c_com_reg.w    <= b_w_reg;
        c_com_reg.rd   <= b_rd_reg;
        c_com_reg.len  <= b_len_reg;
        c_com_reg.thr2 <= THR2_W'(b_thr_reg) * THR2_W'(b_thr_reg);
    end

    // ---------------- stage D: saturation check, divider set-up
    logic                     d_vld_reg;
    logic [NAX-1:0][AD_W-1:0] d_div_reg;
    logic [NAX-1:0][AD_W-1:0] d_rem_reg;
    logic [NAX-1:0][SQ_BITS-1:0] d_low_reg;
    sdiv_side_t               d_side_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            d_vld_reg <= 1'b0;
        end else begin
            d_vld_reg <= c_vld_reg;
        end
    end

    always_ff @(posedge clk) begin
        for (int k = 0; k < NAX; k++) begin
            d_side_reg.sat[k] <= CMP_W'(c_an_reg[k]) >= (CMP_W'(c_ad_reg[k]) << SAT_SHIFT);
            d_rem_reg[k]      <= AD_W'(c_an_reg[k] >> SAT_SHIFT);
            d_low_reg[k]      <= SQ_BITS'(c_an_reg[k] << FRAC_BITS);
        end
        d_div_reg      <= c_ad_reg;
        d_side_reg.c   <= c_com_reg;
        d_side_reg.neg <= c_neg_reg;
        d_side_reg.deg <= c_deg_reg;
    end

    logic                        sd_vld;
    logic [NAX-1:0][SQ_BITS-1:0] sd_quo;
    sdiv_side_t                  sd_side;

    agrp_div #(
        .QW (SQ_BITS),
        .DW (AD_W),
        .SW ($bits(sdiv_side_t))
    ) u_sdiv (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (d_vld_reg),
        .in_div    (d_div_reg),
        .in_rem    (d_rem_reg),
        .in_low    (d_low_reg),
        .in_side   (d_side_reg),
        .out_valid (sd_vld),
        .out_quo   (sd_quo),
        .out_side  (sd_side)
    );

    // ---------------- stage E: signed, saturated ray parameter
    logic                    e_vld_reg;
    logic [NAX-1:0][S_W-1:0] e_s_reg;
    logic [NAX-1:0]          e_deg_reg;
    common_t                 e_com_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            e_vld_reg <= 1'b0;
        end else begin
            e_vld_reg <= sd_vld;
        end
    end

    always_ff @(posedge clk) begin
        for (int k = 0; k < NAX; k++) begin
            logic [SQ_BITS-1:0] mag;
            mag = sd_side.sat[k] ? '1 : sd_quo[k];
            if (sd_side.deg[k]) begin
                e_s_reg[k] <= '0;
            end else if (sd_side.neg[k]) begin
                e_s_reg[k] <= -S_W'(mag);
            end else begin
                e_s_reg[k] <= S_W'(mag);
            end
        end
        e_deg_reg <= sd_side.deg;
        e_com_reg <= sd_side.c;
    end

    // ---------------- stage F: segment numerator
    logic                     f_vld_reg;
    logic [NAX-1:0][TN_W-1:0] f_tn_reg;
    logic [NAX-1:0][S_W-1:0]  f_s_reg;
    logic [NAX-1:0]           f_deg_reg;
    common_t                  f_com_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            f_vld_reg <= 1'b0;
        end else begin
            f_vld_reg <= e_vld_reg;
        end
    end

    always_ff @(posedge clk) begin
        for (int k = 0; k < NAX; k++) begin
            f_tn_reg[k] <= TN_W'($signed(e_com_reg.rd[k])) * TN_W'($signed(e_s_reg[k]))
                         + (TN_W'($signed(e_com_reg.w[k])) <<< FRAC_BITS);
        end
        f_s_reg   <= e_s_reg;
        f_deg_reg <= e_deg_reg;
        f_com_reg <= e_com_reg;
    end

    // ---------------- stage G: clamp decision, second divider set-up
    logic                       g_vld_reg;
    logic [NAX-1:0][LEN_W-1:0]  g_div_reg;
    logic [NAX-1:0][LEN_W-1:0]  g_rem_reg;
    logic [NAX-1:0][T_BITS-1:0] g_low_reg;
    tdiv_side_t                 g_side_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            g_vld_reg <= 1'b0;
        end else begin
            g_vld_reg <= f_vld_reg;
        end
    end

    always_ff @(posedge clk) begin
        for (int k = 0; k < NAX; k++) begin
            logic signed [TN_W-1:0] tn;
            tn = $signed(f_tn_reg[k]);
            priority if (f_deg_reg[k]) begin
                g_side_reg.tsel[k] <= TS_ZERO;
            end else if (tn <= 0) begin
                g_side_reg.tsel[k] <= TS_ZERO;
            end else if (tn >= $signed(TN_W'(f_com_reg.len) << FRAC_BITS)) begin
                g_side_reg.tsel[k] <= TS_ONE;
            end else begin
                g_side_reg.tsel[k] <= TS_DIV;
            end
            g_rem_reg[k] <= LEN_W'(f_tn_reg[k] >> FRAC_BITS);
            g_low_reg[k] <= f_tn_reg[k][T_BITS-1:0];
            g_div_reg[k] <= f_com_reg.len;
        end
        g_side_reg.c <= f_com_reg;
        g_side_reg.s <= f_s_reg;
    end

    logic                       td_vld;
    logic [NAX-1:0][T_BITS-1:0] td_quo;
    tdiv_side_t                 td_side;

    agrp_div #(
        .QW (T_BITS),
        .DW (LEN_W),
        .SW ($bits(tdiv_side_t))
    ) u_tdiv (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (g_vld_reg),
        .in_div    (g_div_reg),
        .in_rem    (g_rem_reg),
        .in_low    (g_low_reg),
        .in_side   (g_side_reg),
        .out_valid (td_vld),
        .out_quo   (td_quo),
        .out_side  (td_side)
    );

    // ---------------- stage H: final parameters
    logic                        h_vld_reg;
    logic [NAX-1:0][T_W-1:0]     h_t_reg;
    logic [NAX-1:0][SQ_BITS-1:0] h_sc_reg;
    common_t                     h_com_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            h_vld_reg <= 1'b0;
        end else begin
            h_vld_reg <= td_vld;
        end
    end

    always_ff @(posedge clk) begin
        for (int k = 0; k < NAX; k++) begin
            unique case (td_side.tsel[k])
                TS_ONE:  h_t_reg[k] <= ONE_T;
                TS_DIV:  h_t_reg[k] <= T_W'(td_quo[k]);
                default: h_t_reg[k] <= '0;
            endcase
            // drop the ray parameter to zero behind the ray origin
            h_sc_reg[k] <= td_side.s[k][S_W-1] ? '0 : td_side.s[k][SQ_BITS-1:0];
        end
        h_com_reg <= td_side.c;
    end

    // ---------------- stage I: closest-point products
    logic                                 i_vld_reg;
    logic [NAX-1:0][NAX-1:0][MRD_W-1:0]   i_mrd_reg;
    logic [NAX-1:0][ML_W-1:0]             i_ml_reg;
    logic [NAX-1:0][W_W-1:0]              i_w_reg;
    logic [THR2_W-1:0]                    i_thr2_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            i_vld_reg <= 1'b0;
        end else begin
            i_vld_reg <= h_vld_reg;
        end
    end

    always_ff @(posedge clk) begin
        for (int k = 0; k < NAX; k++) begin
            for (int i = 0; i < NAX; i++) begin
                i_mrd_reg[k][i] <= MRD_W'($signed(h_com_reg.rd[i]))
                                 * MRD_W'($signed({1'b0, h_sc_reg[k]}));
            end
            i_ml_reg[k] <= ML_W'(h_com_reg.len) * ML_W'(h_t_reg[k]);
        end
        i_w_reg    <= h_com_reg.w;
        i_thr2_reg <= h_com_reg.thr2;
    end

    // ---------------- stage J: difference vectors, capped magnitudes
    logic                               j_vld_reg;
    logic [NAX-1:0][NAX-1:0][CAP_W-1:0] j_abs_reg, j_abs_next;
    logic [THR2_W-1:0]                  j_thr2_reg;

    always_comb begin
        logic signed [MRD_W-1:0] msh;
        logic signed [DF_W-1:0]  dv;
        logic [DF_W-1:0]         mag;
        msh = '0;
        dv  = '0;
        mag = '0;
        for (int k = 0; k < NAX; k++) begin
            for (int i = 0; i < NAX; i++) begin
                msh = $signed(i_mrd_reg[k][i]) >>> FRAC_BITS;
                dv  = DF_W'($signed(i_w_reg[i])) + DF_W'(msh);
                if (i == k) begin
                    dv = dv - $signed(DF_W'(i_ml_reg[k] >> FRAC_BITS));
                end
                mag = dv[DF_W-1] ? DF_W'(-dv) : DF_W'(dv);
                j_abs_next[k][i] = (mag > DF_W'(DIFF_CAP)) ? DIFF_CAP : mag[CAP_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            j_vld_reg <= 1'b0;
        end else begin
            j_vld_reg <= i_vld_reg;
        end
    end

    always_ff @(posedge clk) begin
        j_abs_reg  <= j_abs_next;
        j_thr2_reg <= i_thr2_reg;
    end

    // ---------------- stage K: squares
    logic                               k_vld_reg;
    logic [NAX-1:0][NAX-1:0][SQR_W-1:0] k_sq_reg;
    logic [THR2_W-1:0]                  k_thr2_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            k_vld_reg <= 1'b0;
        end else begin
            k_vld_reg <= j_vld_reg;
        end
    end

    always_ff @(posedge clk) begin
        for (int k = 0; k < NAX; k++) begin
            for (int i = 0; i < NAX; i++) begin
                k_sq_reg[k][i] <= SQR_W'(j_abs_reg[k][i]) * SQR_W'(j_abs_reg[k][i]);
            end
        end
        k_thr2_reg <= j_thr2_reg;
    end

    // ---------------- stage L: squared distances
    logic                      l_vld_reg;
    logic [NAX-1:0][SQR_W-1:0] l_dist2_reg;
    logic [SQR_W-1:0]          l_thr2_reg;
    logic                      l_all_far;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            l_vld_reg <= 1'b0;
        end else begin
            l_vld_reg <= k_vld_reg;
        end
    end

    always_ff @(posedge clk) begin
        for (int k = 0; k < NAX; k++) begin
            l_dist2_reg[k] <= k_sq_reg[k][0] + k_sq_reg[k][1] + k_sq_reg[k][2];
        end
        l_thr2_reg <= SQR_W'(k_thr2_reg);
    end

    assign l_all_far = (l_dist2_reg[0] >= l_thr2_reg) && (l_dist2_reg[1] >= l_thr2_reg)
                    && (l_dist2_reg[2] >= l_thr2_reg);

    // ---------------- stage M: pick, earlier axis wins a tie
    axis_t pick_next;
    axis_t picked_axis_reg;
    logic  done_reg;

    always_comb begin
        logic             have;
        logic [SQR_W-1:0] best;
        have      = 1'b0;
        best      = '0;
        pick_next = AXIS_NONE;
        for (int k = 0; k < NAX; k++) begin
            if ((l_dist2_reg[k] < l_thr2_reg) && (!have || (l_dist2_reg[k] < best))) begin
                have      = 1'b1;
                best      = l_dist2_reg[k];
                pick_next = AXIS_OF[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            done_reg <= 1'b0;
        end else begin
            done_reg <= l_vld_reg;
        end
    end

    always_ff @(posedge clk) begin
        picked_axis_reg <= pick_next;
    end

    assign done        = done_reg;
    assign picked_axis = picked_axis_reg;

    `AGRP_ASSERT_IMPLY(a_done_has_item, done, $past(start, LATENCY))
    `AGRP_ASSERT_IMPLY(a_item_gives_done, start, ##LATENCY done)
    `AGRP_ASSERT_NEXT(a_far_picks_none, l_vld_reg && l_all_far, picked_axis == AXIS_NONE)

endmodule
